/* sv/sci_pkg.sv */
// Types, command codes and the BCD helper of the serial calendar interface.
package sci_pkg;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    localparam logic [3:0] CMD_WEEKDAY = 4'h0;
    localparam logic [3:0] CMD_HOUR    = 4'h2;
    localparam logic [3:0] CMD_SECOND  = 4'h4;
    localparam logic [3:0] CMD_MONTH   = 4'h6;
    localparam logic [3:0] CMD_ZERO    = 4'h8;
    localparam logic [3:0] CMD_DAY     = 4'ha;
    localparam logic [3:0] CMD_MINUTE  = 4'hc;
    localparam logic [3:0] CMD_YEAR    = 4'he;
    localparam logic [3:0] CMD_ONE     = 4'hf;

    localparam logic [7:0] VALUE_ODD_CMD = 8'h02;
    localparam logic [7:0] VALUE_ONE     = 8'h01;
    localparam logic [1:0] LAST_BIT      = 2'd3;

    typedef struct packed {
        logic       operation;
        logic       command_bit;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [6:0] year_in_century;
    } t_in_item;

    typedef struct packed {
        logic read_bit;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_stage;

    // Converts a value below 100 to two BCD digits; the tens digit comes from
    // a multiplication by the reciprocal of ten.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  units;
        prod     = 15'(v) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        units    = v - tens_x10;
        return {tens, units[3:0]};
    endfunction

    function automatic logic [6:0] year_mod100(input logic [6:0] v);
        return (v >= 7'd100) ? (v - 7'd100) : v;
    endfunction

endpackage

/* sv/sci_in_if.sv */
// Handshake channel that carries one bus access item into the block.
interface sci_in_if;
    logic              valid;
    logic              ready;
    sci_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

/* sv/sci_out_if.sv */
// Handshake channel that carries one result item out of the block.
interface sci_out_if;
    logic               valid;
    logic               ready;
    sci_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

/* sv/sci_in_stage.sv */
// Input register stage that holds one accepted bus access item.
module sci_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sci_in_if.sink         i_in,
    input  logic           i_advance,
    output sci_pkg::t_stage o_stage
);
    import sci_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;
    logic     take;

    assign i_in.ready = !r_valid || i_advance;
    assign take       = i_in.valid && i_in.ready;
    assign n_valid    = take || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_in.item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;
endmodule

/* sv/sci_core.sv */
// Command shifter, value selection, read mask and result register.
module sci_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sci_pkg::t_stage i_stage,
    output logic            o_advance,
    sci_out_if.source       o_out
);
    import sci_pkg::*;

    logic [3:0] r_command_shift;
    logic [1:0] r_bit_count;
    logic [7:0] r_value_byte;
    logic [7:0] r_read_mask;
    logic       r_out_valid;
    logic       r_read_bit;

    logic [3:0] n_command_shift;
    logic [1:0] n_bit_count;
    logic [7:0] n_value_byte;
    logic [7:0] n_read_mask;
    logic       n_out_valid;
    logic       n_read_bit;
    logic [3:0] shifted_cmd;
    logic [7:0] selected;
    t_in_item   it;

    assign it          = i_stage.item;
    assign o_advance   = i_stage.valid && (!r_out_valid || o_out.ready);
    assign shifted_cmd = {r_command_shift[2:0], it.command_bit};

    always_comb begin
        unique case (shifted_cmd)
            CMD_WEEKDAY: selected = to_bcd({4'b0, it.weekday});
            CMD_HOUR:    selected = to_bcd({2'b0, it.hour});
            CMD_SECOND:  selected = to_bcd({1'b0, it.second});
            CMD_MONTH:   selected = to_bcd({3'b0, it.month});
            CMD_ZERO:    selected = 8'h00;
            CMD_DAY:     selected = to_bcd({2'b0, it.day_of_month});
            CMD_MINUTE:  selected = to_bcd({1'b0, it.minute});
            CMD_YEAR:    selected = to_bcd(year_mod100(it.year_in_century));
            CMD_ONE:     selected = VALUE_ONE;
            default:     selected = VALUE_ODD_CMD;
        endcase
    end

    always_comb begin
        n_command_shift = shifted_cmd;
        n_bit_count     = r_bit_count;
        n_value_byte    = r_value_byte;
        n_read_mask     = r_read_mask;
        n_read_bit      = r_read_bit;
        n_out_valid     = r_out_valid && !o_out.ready;
        if (o_advance) begin
            n_out_valid = 1'b1;
            if (t_op'(it.operation) == OP_READ) begin
                n_command_shift = r_command_shift;
                n_read_bit      = |(r_value_byte & r_read_mask);
                n_read_mask     = {r_read_mask[6:0], 1'b0};
            end else begin
                n_read_bit = 1'b0;
                if (r_bit_count == LAST_BIT) begin
                    n_bit_count  = 2'd0;
                    n_read_mask  = 8'h01;
                    n_value_byte = selected;
                end else begin
                    n_bit_count = r_bit_count + 2'd1;
                end
            end
        end else begin
            n_command_shift = r_command_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_shift <= 4'd0;
            r_bit_count     <= 2'd0;
            r_value_byte    <= 8'd0;
            r_read_mask     <= 8'd0;
            r_out_valid     <= 1'b0;
        end else begin
            r_command_shift <= n_command_shift;
            r_bit_count     <= n_bit_count;
            r_value_byte    <= n_value_byte;
            r_read_mask     <= n_read_mask;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_bit <= n_read_bit;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.item.read_bit = r_read_bit;

    a_mask_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_read_mask))
        else $error("Read mask has more than one bit set.");

    a_latch_on_fourth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && (it.operation == OP_WRITE) && (r_bit_count == LAST_BIT)
        |=> (r_read_mask == 8'h01) && (r_bit_count == 2'd0))
        else $error("Fourth command bit did not latch the command.");

    a_write_returns_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && (it.operation == OP_WRITE) |=> r_out_valid && !r_read_bit)
        else $error("Write item produced a nonzero read bit.");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_advance |=> $stable(r_command_shift) && $stable(r_bit_count)
            && $stable(r_value_byte) && $stable(r_read_mask))
        else $error("State changed without an item.");
endmodule

/* sv/serial_calendar_interface_unit.sv */
// Top level of the bit-serial calendar chip interface.
//
//   Channel  Direction  Payload
//   i_in     in         operation, command_bit and the current time fields
//   o_out    out        read_bit
//
// An item is taken into the input register, processed, and its result is
// registered in the output register.
// One item is accepted in every cycle while o_out does not stall; the input
// register and the result register keep the two sides apart.
// A stall on o_out holds the result and the pending item; i_in.ready drops
// only when both registers are full.
// Synchronous active-low reset clears the command, count, value, mask and valid flags.
module serial_calendar_interface_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sci_in_if.sink    i_in,
    sci_out_if.source o_out
);
    import sci_pkg::*;

    t_stage stage;
    logic   advance;

    sci_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_stage   (stage)
    );

    sci_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .o_advance (advance),
        .o_out     (o_out)
    );
endmodule

/* tb/sv/tb_serial_calendar_interface_unit.sv */
// Self-checking testbench of the bit-serial calendar interface with its own prediction.
module tb_serial_calendar_interface_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sci_pkg::*;

    localparam int PHASE_ITEMS = 212;

    logic i_clk;
    logic i_rst_n;

    sci_in_if  in_ch();
    sci_out_if out_ch();

    serial_calendar_interface_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted state of the calendar interface.
    logic [3:0] cmd_sr;
    logic [1:0] wr_count;
    logic [7:0] sel_value;
    logic [7:0] bit_sel;

    t_in_item pending_items[$];
    logic     expected_bits[$];
    int       n_pushed;
    int       n_accepted;
    int       n_errors;
    int       gen_wr_count;
    int       idle_pct;
    logic     in_took;
    logic     sender_idles;
    logic     rcv_stalls;

    always #6 i_clk = ~i_clk;

    function automatic logic [7:0] bcd_of(input int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic logic [7:0] time_value(input logic [3:0] cmd, input t_in_item it);
        case (cmd)
            CMD_WEEKDAY: return bcd_of(int'(it.weekday));
            CMD_HOUR:    return bcd_of(int'(it.hour));
            CMD_SECOND:  return bcd_of(int'(it.second));
            CMD_MONTH:   return bcd_of(int'(it.month));
            CMD_ZERO:    return 8'h00;
            CMD_DAY:     return bcd_of(int'(it.day_of_month));
            CMD_MINUTE:  return bcd_of(int'(it.minute));
            CMD_YEAR:    return bcd_of(int'(it.year_in_century) % 100);
            CMD_ONE:     return VALUE_ONE;
            default:     return VALUE_ODD_CMD;
        endcase
    endfunction

    function automatic logic calendar_predict(input t_in_item it);
        logic bit_out;
        bit_out = 1'b0;
        if (t_op'(it.operation) == OP_READ) begin
            bit_out = |(sel_value & bit_sel);
            bit_sel = bit_sel << 1;
        end else begin
            cmd_sr = {cmd_sr[2:0], it.command_bit};
            if (wr_count == LAST_BIT) begin
                wr_count  = 2'd0;
                bit_sel   = 8'h01;
                sel_value = time_value(cmd_sr, it);
            end else begin
                wr_count = wr_count + 2'd1;
            end
        end
        return bit_out;
    endfunction

    // Fill 0 gives random time fields, 1 all ones, 2 all zeros.
    function automatic t_in_item make_item(input t_op op, input logic cbit, input int fill);
        t_in_item it;
        it.operation   = op;
        it.command_bit = cbit;
        if (fill == 1) begin
            {it.weekday, it.hour, it.minute, it.second, it.month, it.day_of_month,
             it.year_in_century} = '1;
        end else if (fill == 2) begin
            {it.weekday, it.hour, it.minute, it.second, it.month, it.day_of_month,
             it.year_in_century} = '0;
        end else if ($urandom_range(0, 3) == 0) begin
            {it.weekday, it.hour, it.minute, it.second, it.month, it.day_of_month,
             it.year_in_century} = 36'($urandom) ^ (36'($urandom) << 32);
        end else begin
            it.weekday         = 3'($urandom_range(0, 6));
            it.hour            = 5'($urandom_range(0, 23));
            it.minute          = 6'($urandom_range(0, 59));
            it.second          = 6'($urandom_range(0, 59));
            it.month           = 4'($urandom_range(1, 12));
            it.day_of_month    = 5'($urandom_range(1, 31));
            it.year_in_century = 7'($urandom_range(0, 99));
        end
        return it;
    endfunction

    task automatic push_item(input t_in_item it);
        pending_items.push_back(it);
        n_pushed++;
        if (t_op'(it.operation) == OP_WRITE) begin
            gen_wr_count = (gen_wr_count + 1) % 4;
        end
    endtask

    task automatic push_reads(input int count);
        for (int k = 0; k < count; k++) begin
            push_item(make_item(OP_READ, 1'($urandom), 0));
        end
    endtask

    task automatic push_command(input logic [3:0] cmd, input int fill);
        while (gen_wr_count != 0) begin
            push_item(make_item(OP_WRITE, 1'($urandom), 0));
        end
        for (int k = 3; k >= 1; k--) begin
            push_item(make_item(OP_WRITE, cmd[k], 0));
        end
        push_item(make_item(OP_WRITE, cmd[0], fill));
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed || expected_bits.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || in_took)) begin
            if (pending_items.size() != 0
                && !(sender_idles && $urandom_range(0, 99) < idle_pct)) begin
                in_ch.valid <= 1'b1;
                in_ch.item  <= pending_items.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= i_rst_n && !(rcv_stalls && $urandom_range(0, 99) < idle_pct);
    end

    always @(posedge i_clk) begin
        in_took <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_bits.size() == 0) begin
                    $display("%0t: result with no item pending, actual read_bit %b",
                             $time, out_ch.item.read_bit);
                    n_errors++;
                end else if (out_ch.item.read_bit !== expected_bits[0]) begin
                    $display("%0t: read_bit mismatch, expected %b, actual %b",
                             $time, expected_bits[0], out_ch.item.read_bit);
                    n_errors++;
                    void'(expected_bits.pop_front());
                end else begin
                    void'(expected_bits.pop_front());
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_bits.push_back(calendar_predict(in_ch.item));
                n_accepted++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int phase_start;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.item   = '0;
        out_ch.ready = 1'b0;
        in_took      = 1'b0;
        sender_idles = 1'b0;
        rcv_stalls   = 1'b0;
        idle_pct     = 0;
        cmd_sr       = '0;
        wr_count     = '0;
        sel_value    = '0;
        bit_sel      = '0;
        n_pushed     = 0;
        n_accepted   = 0;
        n_errors     = 0;
        gen_wr_count = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reads before any command, then full-scale fields read past eight bits.
        push_reads(2);
        push_command(CMD_YEAR, 1);
        push_reads(9);
        push_command(CMD_WEEKDAY, 1);
        push_reads(8);

        for (int ph = 0; ph < 4; ph++) begin
            sender_idles = (ph == 1) || (ph == 3);
            rcv_stalls   = (ph == 2) || (ph == 3);
            idle_pct     = (ph == 3) ? 27 : 73;
            phase_start  = n_pushed;
            while (n_pushed - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        push_item(make_item(t_op'($urandom_range(0, 1)), 1'($urandom),
                                            $urandom_range(0, 2)));
                    end
                end else begin
                    push_command(4'($urandom_range(0, 15)), ($urandom_range(0, 7) == 0) ?
                                 $urandom_range(1, 2) : 0);
                    push_reads($urandom_range(0, 10));
                end
            end
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/sci_pkg.sv
sv/sci_in_if.sv
sv/sci_out_if.sv
sv/sci_in_stage.sv
sv/sci_core.sv
sv/serial_calendar_interface_unit.sv
tb/sv/tb_serial_calendar_interface_unit.sv
